FILE: hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: never");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next");

`endif

FILE: hw/rtl/tss_pkg.sv
package tss_pkg;

   localparam int MaxSamples = 4096;
   localparam int CntW      = 13;
   localparam int AngW      = 16;
   localparam int SumW      = 28;
   localparam int SqW       = 43;
   localparam int PeakW     = 32;
   localparam int WideW     = 56;
   localparam int DivW      = 25;
   localparam int RemW      = 26;
   localparam int OutW      = 15;
   localparam int DivSteps  = 56;
   localparam int SqrtSteps = 28;
   localparam int StepW     = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_SAVE,
      ST_SQ_LOAD,
      ST_SQ_RUN,
      ST_SQ_SAVE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      JOB_PITCH = 2'd0,
      JOB_ROLL  = 2'd1,
      JOB_PEAK  = 2'd2,
      JOB_RMS   = 2'd3
   } job_type;

   typedef struct packed {
      logic    accumulate;
      logic    mul;
      logic    diff;
      logic    div_load;
      logic    div_step;
      logic    div_save;
      logic    sq_load;
      logic    sq_step;
      logic    sq_save;
      logic    emit;
      job_type job;
   } cmd_type;

endpackage

FILE: hw/rtl/tss_ctrl.sv
`include "assert_macros.svh"

module tss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_has_sample,
   input  logic              req_last,
   output logic              busy,
   output tss_pkg::cmd_type  cmd
);

   tss_pkg::state_type state_ff, state_in;
   logic [tss_pkg::StepW-1:0] cnt_ff, cnt_in;
   tss_pkg::job_type job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tss_pkg::ST_IDLE;
         cnt_ff   <= '0;
         job_ff   <= tss_pkg::JOB_PITCH;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      busy     = 1'b1;
      case (state_ff)
         tss_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.accumulate = start & req_has_sample;
            if (start && req_last) begin
               state_in = tss_pkg::ST_MUL;
            end
         end
         tss_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = tss_pkg::ST_DIFF;
         end
         tss_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            job_in   = tss_pkg::JOB_PITCH;
            state_in = tss_pkg::ST_DIV_LOAD;
         end
         tss_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = tss_pkg::ST_DIV_RUN;
         end
         tss_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == tss_pkg::StepW'(tss_pkg::DivSteps - 1)) begin
               state_in = tss_pkg::ST_DIV_SAVE;
            end
         end
         tss_pkg::ST_DIV_SAVE: begin
            cmd.div_save = 1'b1;
            if (job_ff == tss_pkg::JOB_ROLL) begin
               job_in   = tss_pkg::JOB_RMS;
               state_in = tss_pkg::ST_DIV_LOAD;
            end else if (job_ff == tss_pkg::JOB_RMS) begin
               job_in   = tss_pkg::JOB_PITCH;
               state_in = tss_pkg::ST_SQ_LOAD;
            end else begin
               job_in   = tss_pkg::JOB_ROLL;
               state_in = tss_pkg::ST_DIV_LOAD;
            end
         end
         tss_pkg::ST_SQ_LOAD: begin
            cmd.sq_load = 1'b1;
            cnt_in      = '0;
            state_in    = tss_pkg::ST_SQ_RUN;
         end
         tss_pkg::ST_SQ_RUN: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == tss_pkg::StepW'(tss_pkg::SqrtSteps - 1)) begin
               state_in = tss_pkg::ST_SQ_SAVE;
            end
         end
         tss_pkg::ST_SQ_SAVE: begin
            cmd.sq_save = 1'b1;
            if (job_ff == tss_pkg::JOB_RMS) begin
               state_in = tss_pkg::ST_EMIT;
            end else begin
               job_in   = tss_pkg::job_type'(job_ff + 2'd1);
               state_in = tss_pkg::ST_SQ_LOAD;
            end
         end
         tss_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = tss_pkg::ST_IDLE;
         end
         default: begin
            state_in = tss_pkg::ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEVER(a_step_overlap, clock, reset, cmd.div_step && cmd.sq_step)
   `ASSERT_NEXT(a_emit_idle, clock, reset, cmd.emit, !busy)
   `ASSERT_NEVER(a_div_cnt, clock, reset,
      cmd.div_step && (cnt_ff > tss_pkg::StepW'(tss_pkg::DivSteps - 1)))

endmodule

FILE: hw/rtl/tss_datapath.sv
module tss_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tss_pkg::cmd_type                  cmd,
   input  logic signed [tss_pkg::AngW-1:0]   req_pitch,
   input  logic signed [tss_pkg::AngW-1:0]   req_roll,
   output logic                              rsp_valid,
   output logic [tss_pkg::OutW-1:0]          rsp_std_pitch,
   output logic [tss_pkg::OutW-1:0]          rsp_std_roll,
   output logic [tss_pkg::OutW-1:0]          rsp_peak_dev,
   output logic [tss_pkg::OutW-1:0]          rsp_rms_dev,
   output logic [tss_pkg::CntW-1:0]          rsp_sample_count,
   output logic                              rsp_overflow
);

   localparam int W = tss_pkg::WideW;

   logic signed [tss_pkg::SumW-1:0] sum_p_ff, sum_r_ff;
   logic [tss_pkg::SqW-1:0]   sq_p_ff, sq_r_ff;
   logic [tss_pkg::PeakW-1:0] peak_ff;
   logic [tss_pkg::CntW-1:0]  taken_ff;
   logic                      dropped_ff;
   logic                      valid_ff;

   logic [W-1:0] a_p_ff, b_p_ff, a_r_ff, b_r_ff, num_p_ff, num_r_ff;
   logic [tss_pkg::DivW-1:0] nn_ff;
   logic [W-1:0] q_p_ff, q_r_ff, q_m_ff;
   logic [W-1:0] dvd_ff, dvd_in;
   logic [tss_pkg::RemW-1:0] rem_ff, rem_in, rem_sh;
   logic [tss_pkg::DivW-1:0] dvs_ff, dvs_in;
   logic [W-1:0] x_ff, res_ff, bit_ff, x_sel, trial;
   logic [tss_pkg::OutW-1:0] o_p_ff, o_r_ff, o_k_ff, o_m_ff, sat;

   logic signed [2*tss_pkg::AngW-1:0] pp_s, rr_s;
   logic [tss_pkg::PeakW-1:0] pp, rr, pr;
   logic [tss_pkg::SumW-1:0] mag_p, mag_r;

   always_comb begin
      pp_s  = req_pitch * req_pitch;
      rr_s  = req_roll * req_roll;
      pp    = tss_pkg::PeakW'(pp_s);
      rr    = tss_pkg::PeakW'(rr_s);
      pr    = pp + rr;
      mag_p = sum_p_ff[tss_pkg::SumW-1] ? tss_pkg::SumW'(-sum_p_ff) : sum_p_ff;
      mag_r = sum_r_ff[tss_pkg::SumW-1] ? tss_pkg::SumW'(-sum_r_ff) : sum_r_ff;
   end

   // statistics accumulators
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         sum_p_ff   <= '0;
         sum_r_ff   <= '0;
         sq_p_ff    <= '0;
         sq_r_ff    <= '0;
         peak_ff    <= '0;
         taken_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.accumulate) begin
         if (taken_ff < tss_pkg::CntW'(tss_pkg::MaxSamples)) begin
            sum_p_ff <= sum_p_ff + tss_pkg::SumW'(req_pitch);
            sum_r_ff <= sum_r_ff + tss_pkg::SumW'(req_roll);
            sq_p_ff  <= sq_p_ff + tss_pkg::SqW'(pp);
            sq_r_ff  <= sq_r_ff + tss_pkg::SqW'(rr);
            if (pr > peak_ff) begin
               peak_ff <= pr;
            end
            taken_ff <= taken_ff + 1'b1;
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // products and differences
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         a_p_ff <= W'(taken_ff) * W'(sq_p_ff);
         a_r_ff <= W'(taken_ff) * W'(sq_r_ff);
         b_p_ff <= W'(mag_p) * W'(mag_p);
         b_r_ff <= W'(mag_r) * W'(mag_r);
         nn_ff  <= tss_pkg::DivW'(taken_ff) * tss_pkg::DivW'(taken_ff);
      end
      if (cmd.diff) begin
         num_p_ff <= (a_p_ff > b_p_ff) ? a_p_ff - b_p_ff : '0;
         num_r_ff <= (a_r_ff > b_r_ff) ? a_r_ff - b_r_ff : '0;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      rem_sh = {rem_ff[tss_pkg::RemW-2:0], dvd_ff[W-1]};
      if (cmd.div_load) begin
         rem_in = '0;
         case (cmd.job)
            tss_pkg::JOB_PITCH: begin
               dvd_in = num_p_ff;
               dvs_in = nn_ff;
            end
            tss_pkg::JOB_ROLL: begin
               dvd_in = num_r_ff;
               dvs_in = nn_ff;
            end
            default: begin
               dvd_in = W'(sq_p_ff) + W'(sq_r_ff);
               dvs_in = tss_pkg::DivW'(taken_ff);
            end
         endcase
      end else if (cmd.div_step) begin
         if (rem_sh >= tss_pkg::RemW'(dvs_ff)) begin
            rem_in = rem_sh - tss_pkg::RemW'(dvs_ff);
            dvd_in = {dvd_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dvd_in = {dvd_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (cmd.div_save) begin
         case (cmd.job)
            tss_pkg::JOB_PITCH: q_p_ff <= dvd_ff;
            tss_pkg::JOB_ROLL:  q_r_ff <= dvd_ff;
            default:            q_m_ff <= dvd_ff;
         endcase
      end
   end

   // digit by digit square root, two radicand bits per cycle
   always_comb begin
      case (cmd.job)
         tss_pkg::JOB_PITCH: x_sel = q_p_ff;
         tss_pkg::JOB_ROLL:  x_sel = q_r_ff;
         tss_pkg::JOB_PEAK:  x_sel = W'(peak_ff);
         default:            x_sel = q_m_ff;
      endcase
      trial = res_ff + bit_ff;
      sat   = (res_ff > W'(2**tss_pkg::OutW - 1)) ? '1 : res_ff[tss_pkg::OutW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_load) begin
         x_ff   <= x_sel;
         res_ff <= '0;
         bit_ff <= W'(1) << (W - 2);
      end else if (cmd.sq_step) begin
         if (x_ff >= trial) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.sq_save) begin
         case (cmd.job)
            tss_pkg::JOB_PITCH: o_p_ff <= sat;
            tss_pkg::JOB_ROLL:  o_r_ff <= sat;
            tss_pkg::JOB_PEAK:  o_k_ff <= sat;
            default:            o_m_ff <= sat;
         endcase
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_std_pitch    <= (taken_ff == '0) ? '0 : o_p_ff;
         rsp_std_roll     <= (taken_ff == '0) ? '0 : o_r_ff;
         rsp_peak_dev     <= (taken_ff == '0) ? '0 : o_k_ff;
         rsp_rms_dev      <= (taken_ff == '0) ? '0 : o_m_ff;
         rsp_sample_count <= taken_ff;
         rsp_overflow     <= dropped_ff;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

FILE: hw/rtl/tilt_stability_statistics_top.sv
// channel   ports                                         handshake
// request   req_pitch req_roll req_has_sample req_last    start & !busy
// response  rsp_std_* rsp_peak_dev rsp_rms_dev rsp_sample_count rsp_overflow
//                                                         rsp_valid, one cycle
// an item without last leaves the controller idle, the next may follow at once
// an item with last holds busy through multiply, difference, three divides
// and four roots on one shared divider and root unit
// the result beat appears in the first cycle with busy low, for one cycle only
// synchronous reset clears all sums and the controller; the receiver cannot stall
module tilt_stability_statistics_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [tss_pkg::AngW-1:0]  req_pitch,
   input  logic signed [tss_pkg::AngW-1:0]  req_roll,
   input  logic                             req_has_sample,
   input  logic                             req_last,
   output logic                             rsp_valid,
   output logic [tss_pkg::OutW-1:0]         rsp_std_pitch,
   output logic [tss_pkg::OutW-1:0]         rsp_std_roll,
   output logic [tss_pkg::OutW-1:0]         rsp_peak_dev,
   output logic [tss_pkg::OutW-1:0]         rsp_rms_dev,
   output logic [tss_pkg::CntW-1:0]         rsp_sample_count,
   output logic                             rsp_overflow
);

   tss_pkg::cmd_type cmd;

   tss_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_has_sample (req_has_sample),
      .req_last       (req_last),
      .busy           (busy),
      .cmd            (cmd)
   );

   tss_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pitch        (req_pitch),
      .req_roll         (req_roll),
      .rsp_valid        (rsp_valid),
      .rsp_std_pitch    (rsp_std_pitch),
      .rsp_std_roll     (rsp_std_roll),
      .rsp_peak_dev     (rsp_peak_dev),
      .rsp_rms_dev      (rsp_rms_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
